FILE: src/ctf_pkg.sv
package ctf_pkg;

    localparam int unsigned TICKS_DEFAULT = 1000;
    localparam logic [16:0] GYRO_WEIGHT_RESET = 17'd62915;
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic signed [25:0] ANGLE_90 = 26'sd5898240;
    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned SQRT_STEPS = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_SQRT,
        ST_CINIT,
        ST_CORDIC,
        ST_FINISH,
        ST_BLEND1,
        ST_BLEND2,
        ST_BLEND3,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       sq_y;
        logic       sq_z;
        logic       sqrt_step;
        logic       cordic_init;
        logic       cordic_step;
        logic [3:0] iter;
        logic       finish;
        logic       blend1;
        logic       blend2;
        logic       blend3;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic signed [25:0] atan_deg(input logic [3:0] i);
        logic signed [25:0] v;
        unique case (i)
            4'd0:  v = 26'sd2949120;
            4'd1:  v = 26'sd1740967;
            4'd2:  v = 26'sd919879;
            4'd3:  v = 26'sd466945;
            4'd4:  v = 26'sd234379;
            4'd5:  v = 26'sd117304;
            4'd6:  v = 26'sd58666;
            4'd7:  v = 26'sd29335;
            4'd8:  v = 26'sd14668;
            4'd9:  v = 26'sd7334;
            4'd10: v = 26'sd3667;
            4'd11: v = 26'sd1833;
            4'd12: v = 26'sd917;
            4'd13: v = 26'sd458;
            4'd14: v = 26'sd229;
            4'd15: v = 26'sd115;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/ctf_ctrl.sv
module ctf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ctf_pkg::status_t    status,
    output ctf_pkg::cmd_t       cmd
);

    ctf_pkg::state_t state_reg, state_next;
    logic [4:0] iter_reg, iter_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ctf_pkg::ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cmd        = '0;
        cmd.iter   = iter_reg[3:0];
        s_tready   = 1'b0;
        unique case (state_reg)
            ctf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ctf_pkg::ST_SQ_Y;
                end
            end
            ctf_pkg::ST_SQ_Y: begin
                cmd.sq_y   = 1'b1;
                state_next = ctf_pkg::ST_SQ_Z;
            end
            ctf_pkg::ST_SQ_Z: begin
                cmd.sq_z   = 1'b1;
                iter_next  = '0;
                state_next = ctf_pkg::ST_SQRT;
            end
            ctf_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg + 5'd1;
                if (iter_reg == 5'(ctf_pkg::SQRT_STEPS - 1)) begin
                    state_next = ctf_pkg::ST_CINIT;
                end
            end
            ctf_pkg::ST_CINIT: begin
                cmd.cordic_init = 1'b1;
                iter_next       = '0;
                state_next      = ctf_pkg::ST_CORDIC;
            end
            ctf_pkg::ST_CORDIC: begin
                cmd.cordic_step = 1'b1;
                iter_next       = iter_reg + 5'd1;
                if (iter_reg == 5'(ctf_pkg::CORDIC_STEPS - 1)) begin
                    state_next = ctf_pkg::ST_FINISH;
                end
            end
            ctf_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ctf_pkg::ST_BLEND1;
            end
            ctf_pkg::ST_BLEND1: begin
                cmd.blend1 = 1'b1;
                state_next = ctf_pkg::ST_BLEND2;
            end
            ctf_pkg::ST_BLEND2: begin
                cmd.blend2 = 1'b1;
                state_next = ctf_pkg::ST_BLEND3;
            end
            ctf_pkg::ST_BLEND3: begin
                cmd.blend3 = 1'b1;
                state_next = ctf_pkg::ST_DONE;
            end
            ctf_pkg::ST_DONE: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ctf_pkg::ST_IDLE;
                end
            end
            default: state_next = ctf_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: src/ctf_datapath.sv
module ctf_datapath #(
    parameter int unsigned TICKS_PER_SECOND = ctf_pkg::TICKS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [79:0]         s_tdata,
    input  logic                cfg_we,
    input  logic [16:0]         cfg_wdata,
    input  ctf_pkg::cmd_t       cmd,
    output ctf_pkg::status_t    status,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,
    output logic                m_tuser
);

    localparam int unsigned RW = $clog2(TICKS_PER_SECOND + 1);
    localparam logic [RW-1:0] DIVISOR = RW'(TICKS_PER_SECOND);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(TICKS_PER_SECOND));
    localparam logic [15:0] RECIP_LO = RECIP[15:0];
    localparam logic [16:0] RECIP_HI = RECIP[32:16];
    localparam logic [31:0] HALF = 32'(TICKS_PER_SECOND / 2);

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [16:0]        weight_reg;
    logic               init_reg, init_next;
    logic signed [31:0] est_reg, est_next;
    logic signed [31:0] rate_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic               zero_reg;
    logic [31:0]        sq_reg, sq_next;
    logic [47:0]        rem_reg, rem_next;
    logic [47:0]        res_reg, res_next;
    logic [47:0]        bit_reg, bit_next;
    logic signed [27:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [25:0] ang_reg, ang_next;
    logic [2:0]         dcnt_reg, dcnt_next;
    logic [31:0]        dnum_reg, dnum_next;
    logic [47:0]        dlo_reg, dlo_next;
    logic [48:0]        dhi_reg, dhi_next;
    logic [31:0]        dqe_reg, dqe_next;
    logic [31:0]        dqd_reg, dqd_next;
    logic [31:0]        dq_reg, dq_next;
    logic signed [23:0] acc_reg, acc_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [49:0] p1_reg;
    logic signed [41:0] p2_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_tilt_reg;
    logic signed [23:0] out_acc_reg;
    logic               out_zero_reg;

    logic [31:0]        mag;
    logic [16:0]        ax_abs;
    logic [16:0]        w_eff, w_acc;
    logic signed [17:0] w_s, wa_s;
    logic signed [50:0] mix;
    logic signed [34:0] mix_sh;
    logic signed [33:0] isum;
    logic signed [25:0] ang_c;

    assign w_eff  = (weight_reg > ctf_pkg::WEIGHT_ONE) ? ctf_pkg::WEIGHT_ONE : weight_reg;
    assign w_acc  = ctf_pkg::WEIGHT_ONE - w_eff;
    assign w_s    = $signed({1'b0, w_eff});
    assign wa_s   = $signed({1'b0, w_acc});
    assign ax_abs = ax_reg[15] ? 17'(-$signed({ax_reg[15], ax_reg})) : 17'({1'b0, ax_reg});

    always_comb begin
        logic [47:0]   t;
        logic [64:0]   dsum;
        logic [31:0]   drem;
        logic [31:0]   q_add;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        ang_next   = ang_reg;
        dcnt_next  = dcnt_reg;
        dnum_next  = dnum_reg;
        dlo_next   = dlo_reg;
        dhi_next   = dhi_reg;
        dqe_next   = dqe_reg;
        dqd_next   = dqd_reg;
        dq_next    = dq_reg;
        acc_next   = acc_reg;
        integ_next = integ_reg;
        est_next   = est_reg;
        init_next  = init_reg;
        mag        = '0;
        mix        = '0;
        mix_sh     = '0;
        isum       = '0;
        ang_c      = '0;
        q_add      = '0;
        t          = res_reg + bit_reg;
        dsum       = {dhi_reg, 16'd0} + {17'd0, dlo_reg};
        drem       = dnum_reg - dqd_reg;

        if (cmd.load) begin
            mag       = s_tdata[31] ? 32'(-s_tdata[31:0]) : s_tdata[31:0];
            dnum_next = mag + HALF;
            dcnt_next = 3'd5;
        end else begin
            if (dcnt_reg != 3'd0) begin
                dcnt_next = dcnt_reg - 3'd1;
            end
            unique case (dcnt_reg)
                3'd5: dlo_next = 48'(dnum_reg * RECIP_LO);
                3'd4: dhi_next = 49'(dnum_reg * RECIP_HI);
                3'd3: dqe_next = dsum[63:32];
                3'd2: dqd_next = 32'(dqe_reg * DIVISOR);
                3'd1: dq_next  = (drem >= 32'(DIVISOR)) ? dqe_reg + 32'd1 : dqe_reg;
                default: begin
                end
            endcase
        end

        if (cmd.sq_y) begin
            sq_next = 32'($signed(ay_reg) * $signed(ay_reg));
        end
        if (cmd.sq_z) begin
            sq_next  = sq_reg + 32'($signed(az_reg) * $signed(az_reg));
            rem_next = {sq_next, 16'd0};
            res_next = '0;
            bit_next = 48'd1 << 46;
        end
        if (cmd.sqrt_step) begin
            if (rem_reg >= t) begin
                rem_next = rem_reg - t;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
        if (cmd.cordic_init) begin
            cx_next  = $signed({4'd0, res_reg[23:0]});
            cy_next  = $signed({3'd0, ax_abs, 8'd0});
            ang_next = '0;
        end
        if (cmd.cordic_step) begin
            if (cy_reg > 28'sd0) begin
                cx_next  = cx_reg + (cy_reg >>> cmd.iter);
                cy_next  = cy_reg - (cx_reg >>> cmd.iter);
                ang_next = ang_reg + ctf_pkg::atan_deg(cmd.iter);
            end else begin
                cx_next  = cx_reg - (cy_reg >>> cmd.iter);
                cy_next  = cy_reg + (cx_reg >>> cmd.iter);
                ang_next = ang_reg - ctf_pkg::atan_deg(cmd.iter);
            end
        end
        if (cmd.finish) begin
            if (ang_reg < 26'sd0) begin
                ang_c = '0;
            end else if (ang_reg > ctf_pkg::ANGLE_90) begin
                ang_c = ctf_pkg::ANGLE_90;
            end else begin
                ang_c = ang_reg;
            end
            if (zero_reg) begin
                acc_next = '0;
            end else if (ax_reg[15]) begin
                acc_next = 24'(-ang_c);
            end else begin
                acc_next = ang_c[23:0];
            end
            q_add = dq_reg;
            if (rate_reg[31]) begin
                isum = 34'(est_reg) - $signed({2'b00, q_add});
            end else begin
                isum = 34'(est_reg) + $signed({2'b00, q_add});
            end
            integ_next = sat32(35'(isum));
        end
        if (cmd.blend3) begin
            mix    = 51'(p1_reg) + 51'(p2_reg) + 51'sd32768;
            mix_sh = 35'(mix >>> 16);
            if (init_reg) begin
                est_next = sat32(mix_sh);
            end else begin
                est_next = 32'(acc_reg);
            end
            init_next = 1'b1;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign out_valid_next  = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg    <= ctf_pkg::GYRO_WEIGHT_RESET;
            init_reg      <= 1'b0;
            est_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                weight_reg <= cfg_wdata;
            end
            init_reg      <= init_next;
            est_reg       <= est_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rate_reg <= $signed(s_tdata[31:0]);
            ax_reg   <= $signed(s_tdata[47:32]);
            ay_reg   <= $signed(s_tdata[63:48]);
            az_reg   <= $signed(s_tdata[79:64]);
            zero_reg <= (s_tdata[79:32] == 48'd0);
        end
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        ang_reg   <= ang_next;
        dnum_reg  <= dnum_next;
        dlo_reg   <= dlo_next;
        dhi_reg   <= dhi_next;
        dqe_reg   <= dqe_next;
        dqd_reg   <= dqd_next;
        dq_reg    <= dq_next;
        acc_reg   <= acc_next;
        integ_reg <= integ_next;
        if (cmd.blend1) begin
            p1_reg <= w_s * integ_reg;
        end
        if (cmd.blend2) begin
            p2_reg <= wa_s * acc_reg;
        end
        if (cmd.emit) begin
            out_tilt_reg <= est_reg;
            out_acc_reg  <= acc_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_acc_reg, out_tilt_reg};
    assign m_tuser  = out_zero_reg;

endmodule

FILE: src/complementary_tilt_filter.sv
// Complementary tilt filter.
// The input channel (s_) takes one item per sensor tick: a gyro pitch rate
// and a raw three-axis accelerometer sample. The result channel (m_) gives
// one item per input item: the filtered tilt angle, the accelerometer-only
// angle and a flag that marks an all-zero accelerometer sample.
// The gyro weight is to be written through cfg_we and cfg_wdata while idle;
// the block itself does not enforce this. An item passes through squaring
// of y and z, a 24-step square root and a 16-step CORDIC, which run one
// step per cycle, then a finish step and the blend steps; the tick divider
// runs alongside them. A new item is taken only after the last is emitted.
// Reset clears the angle and the first-item flag, loads the default weight
// and empties the output register.
// A finished result waits in the output register while m_tready is low;
// the next item is still accepted and worked on, and it waits for the
// register to be taken before its own result is written.
module complementary_tilt_filter #(
    parameter int unsigned TICKS_PER_SECOND = ctf_pkg::TICKS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // gyro_rate[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tilt_angle[31:0], accel_tilt[55:32]
    output logic [55:0] m_tdata,
    // zero_magnitude[0]
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata
);

    ctf_pkg::cmd_t    cmd;
    ctf_pkg::status_t status;

    ctf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ctf_datapath #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: src/ctf_checker.sv
module ctf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[55:32]) <= 24'sd5898240)
                  && ($signed(m_tdata[55:32]) >= -24'sd5898240))
        else $error("accelerometer angle out of range");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[55:32] == 24'd0)
        else $error("zero magnitude with nonzero angle");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

endmodule

bind complementary_tilt_filter ctf_checker u_ctf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: test/complementary_tilt_filter_tb.sv
module complementary_tilt_filter_tb;

    localparam int TICKS = 1000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1850;

    typedef struct packed {
        logic signed [31:0] tilt_angle;
        logic signed [23:0] accel_tilt;
        logic               zero_magnitude;
    } tilt_t;

    typedef struct {
        logic [31:0] rate;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic        check_fixed;
        tilt_t       fixed;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic [16:0] cfg_wdata = '0;

    longint angle_est;
    bit     seeded;
    logic [16:0] weight;
    tilt_t  pending_tilts[$];
    int     failures = 0;
    int     idle_cycles = 0;
    bit     stall_pattern_on = 1'b1;
    row_t   rows[$];

    complementary_tilt_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint tilt_from_accel(longint ax, longint ay, longint az);
        longint cx, cy, ang, dx, dy;
        cx = int_sqrt(longint'(ay * ay + az * az) << 16);
        cy = (ax < 0 ? -ax : ax) * 256;
        ang = 0;
        for (int i = 0; i < 16; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (cy > 0) begin
                cx += dx; cy -= dy; ang += longint'(ctf_pkg::atan_deg(4'(i)));
            end else begin
                cx -= dx; cy += dy; ang -= longint'(ctf_pkg::atan_deg(4'(i)));
            end
        end
        if (ang < 0) ang = 0;
        if (ang > 5898240) ang = 5898240;
        return ax < 0 ? -ang : ang;
    endfunction

    function automatic tilt_t predict_tilt(logic [79:0] d);
        longint rate, ax, ay, az, acc, mag, q, integ, w, mix;
        bit zero;
        tilt_t t;
        rate = longint'($signed(d[31:0]));
        ax = longint'($signed(d[47:32]));
        ay = longint'($signed(d[63:48]));
        az = longint'($signed(d[79:64]));
        zero = (ax == 0 && ay == 0 && az == 0);
        acc = zero ? 0 : tilt_from_accel(ax, ay, az);
        if (!seeded) begin
            angle_est = acc;
            seeded = 1'b1;
        end else begin
            mag = rate < 0 ? -rate : rate;
            q = (mag + TICKS / 2) / TICKS;
            integ = clamp32(angle_est + (rate < 0 ? -q : q));
            w = weight > 17'd65536 ? 65536 : longint'(weight);
            mix = w * integ + (65536 - w) * acc + 32768;
            angle_est = clamp32(floor_shift(mix, 16));
        end
        t.tilt_angle = angle_est[31:0];
        t.accel_tilt = acc[23:0];
        t.zero_magnitude = zero;
        return t;
    endfunction

    task automatic send_item(logic [79:0] d);
        pending_tilts.push_back(predict_tilt(d));
        s_tdata <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 120)) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_tilts.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_weight(logic [16:0] w);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        weight = w;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] random_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_rate();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic row_t make_row(logic [31:0] r, logic [15:0] x, logic [15:0] y,
                                      logic [15:0] z, bit chk, tilt_t f);
        row_t rw;
        rw.rate = r; rw.ax = x; rw.ay = y; rw.az = z;
        rw.check_fixed = chk; rw.fixed = f;
        return rw;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tilt_t got;
                tilt_t want;
                got.tilt_angle = m_tdata[31:0];
                got.accel_tilt = m_tdata[55:32];
                got.zero_magnitude = m_tuser;
                if (pending_tilts.size() == 0) begin
                    $error("unexpected item: tilt_angle %0d", $signed(got.tilt_angle));
                    failures++;
                end else begin
                    want = pending_tilts.pop_front();
                    if (got.tilt_angle !== want.tilt_angle) begin
                        $error("tilt_angle expected %0d actual %0d",
                               $signed(want.tilt_angle), $signed(got.tilt_angle));
                        failures++;
                    end
                    if (got.accel_tilt !== want.accel_tilt) begin
                        $error("accel_tilt expected %0d actual %0d",
                               $signed(want.accel_tilt), $signed(got.accel_tilt));
                        failures++;
                    end
                    if (got.zero_magnitude !== want.zero_magnitude) begin
                        $error("zero_magnitude expected %0d actual %0d",
                               want.zero_magnitude, got.zero_magnitude);
                        failures++;
                    end
                end
            end
            if ($urandom_range(0, 199) == 0) stall_pattern_on <= ~stall_pattern_on;
            m_tready <= stall_pattern_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        tilt_t nofix;
        int burst;
        logic [79:0] d;
        nofix = '0;
        angle_est = 0;
        seeded = 1'b0;
        weight = ctf_pkg::GYRO_WEIGHT_RESET;

        // The first item seeds the angle, so all-zero axes give a zero result.
        rows.push_back(make_row(32'h7fff_ffff, 16'h0, 16'h0, 16'h0, 1'b1, '{0, 0, 1'b1}));
        rows.push_back(make_row(32'h0, 16'h7fff, 16'h0, 16'h0, 1'b0, nofix));
        rows.push_back(make_row(32'h8000_0000, 16'h8000, 16'h0, 16'h0, 1'b0, nofix));
        rows.push_back(make_row(32'h0, 16'h0, 16'h7fff, 16'h0, 1'b0, nofix));
        rows.push_back(make_row(32'h7fff_ffff, 16'h0, 16'h0, 16'h8000, 1'b0, nofix));
        rows.push_back(make_row(32'h0, 16'h8000, 16'h8000, 16'h8000, 1'b0, nofix));
        rows.push_back(make_row(32'h7fff_ffff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, nofix));
        rows.push_back(make_row(32'd500, 16'h0001, 16'h0, 16'h0, 1'b0, nofix));
        rows.push_back(make_row(-32'sd500, 16'hffff, 16'h0, 16'h0, 1'b0, nofix));
        rows.push_back(make_row(32'd1499, 16'h0, 16'h0, 16'h0, 1'b0, nofix));
        rows.push_back(make_row(32'hffff_ffff, 16'h0, 16'h0001, 16'hffff, 1'b0, nofix));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            d = {rows[i].az, rows[i].ay, rows[i].ax, rows[i].rate};
            if (rows[i].check_fixed) begin
                void'(predict_tilt(d));
                pending_tilts.push_back(rows[i].fixed);
                s_tdata <= d;
                s_tvalid <= 1'b1;
                do @(posedge aclk); while (!s_tready);
            end else begin
                send_item(d);
            end
        end
        drain();

        // Weight of one keeps the angle on the integrator; drive it with extreme rates.
        write_weight(17'd65536);
        for (int i = 0; i < 6; i++) send_item({48'h0, 32'h7fff_ffff});
        for (int i = 0; i < 6; i++) send_item({48'h0, 32'h8000_0000});
        drain();
        write_weight(17'h1ffff);
        for (int i = 0; i < 4; i++) send_item({48'h0, 32'h7fff_ffff});
        drain();
        write_weight(17'd0);
        send_item({16'h0, 16'h0, 16'h7fff, 32'h0});
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_weight(ctf_pkg::GYRO_WEIGHT_RESET);
                1: write_weight(17'($urandom));
                2: write_weight(17'd65535);
                3: write_weight(17'd1);
                default: write_weight(17'($urandom_range(0, 65536)));
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 5;) begin
                burst = $urandom_range(1, 30);
                for (int b = 0; b < burst && n < RANDOM_ITEMS / 5; b++, n++)
                    send_item({random_axis(), random_axis(), random_axis(), random_rate()});
                if ($urandom_range(0, 2) != 0) pause_sender();
            end
            drain();
        end

        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
